// ===== rtl/core/qte_pkg.sv =====
// Shared types, constants and saturating helpers for the quartic trajectory evaluator.
// No dependencies; every other file of the block takes names from here by scope.
package qte_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int NUM_REGS       = 6;
    localparam int REG_IDX_W      = 3;
    localparam int WIDE_W         = 64;

    // Register map, in word order
    localparam logic [REG_IDX_W-1:0] REG_START_POS  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_START_VEL  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_START_ACC  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_END_VEL    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_END_ACC    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SEG_LENGTH = 3'd5;

    // Derivative orders
    localparam logic [2:0] ORD_POS  = 3'd0;
    localparam logic [2:0] ORD_VEL  = 3'd1;
    localparam logic [2:0] ORD_ACC  = 3'd2;
    localparam logic [2:0] ORD_JERK = 3'd3;
    localparam logic [2:0] ORD_SNAP = 3'd4;

    // Internal values stay within +-(2^62 - 1)
    localparam logic [WIDE_W-1:0]        WIDE_MAX_U = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [WIDE_W-1:0] WIDE_MAX   = 64'sh3FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic                     f;
        logic signed [WIDE_W-1:0] v;
    } t_wres;

    typedef struct packed {
        logic signed [WIDE_W-1:0] sp;
        logic signed [WIDE_W-1:0] sv;
        logic signed [WIDE_W-1:0] k2;
        logic signed [WIDE_W-1:0] k3;
        logic signed [WIDE_W-1:0] k4;
        logic signed [WIDE_W-1:0] k4x4;
        logic signed [WIDE_W-1:0] k4x12;
        logic signed [WIDE_W-1:0] k4x24;
        logic signed [WIDE_W-1:0] k3x3;
        logic signed [WIDE_W-1:0] k3x6;
        logic signed [WIDE_W-1:0] k2x2;
        logic                     cf;
        logic                     f4x4;
        logic                     f4x12;
        logic                     f4x24;
        logic                     f3x3;
        logic                     f3x6;
        logic                     f2x2;
        logic                     len_err;
    } t_coef;

    typedef enum logic [2:0] {
        CS_GP,
        CS_HL,
        CS_L2,
        CS_L3,
        CS_K3,
        CS_K4,
        CS_SCALE,
        CS_READY
    } t_cseq;

    // Saturating add to the internal range
    function automatic t_wres addw(input logic signed [WIDE_W-1:0] a,
                                   input logic signed [WIDE_W-1:0] b);
        logic signed [WIDE_W:0] s;
        logic signed [WIDE_W:0] lim;
        t_wres                  r;
        lim = $signed({1'b0, WIDE_MAX_U});
        s   = $signed({a[WIDE_W-1], a}) + $signed({b[WIDE_W-1], b});
        r.f = 1'b0;
        r.v = s[WIDE_W-1:0];
        if (s > lim) begin
            r.f = 1'b1;
            r.v = WIDE_MAX;
        end else if (s < -lim) begin
            r.f = 1'b1;
            r.v = -WIDE_MAX;
        end
        return r;
    endfunction

    // Saturating multiply by a small constant
    function automatic t_wres mulk(input logic signed [WIDE_W-1:0] a,
                                   input logic [4:0]               k);
        logic signed [WIDE_W+5:0] p;
        logic signed [WIDE_W+5:0] lim;
        t_wres                    r;
        lim = $signed({6'd0, WIDE_MAX_U});
        p   = $signed({{6{a[WIDE_W-1]}}, a}) * $signed({65'd0, k});
        r.f = 1'b0;
        r.v = p[WIDE_W-1:0];
        if (p > lim) begin
            r.f = 1'b1;
            r.v = WIDE_MAX;
        end else if (p < -lim) begin
            r.f = 1'b1;
            r.v = -WIDE_MAX;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/qte_req_if.sv =====
// Query channel of the evaluator: valid/ready handshake with order and parameter value.
// Depends on qte_pkg for the default data width.
interface qte_req_if #(
    parameter int DATA_WIDTH = qte_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic [2:0]                   op;
    logic signed [DATA_WIDTH-1:0] param_value;

    modport source (output valid, op, param_value, input ready);
    modport sink   (input valid, op, param_value, output ready);
endinterface

// ===== rtl/core/qte_rsp_if.sv =====
// Result channel of the evaluator: valid/ready handshake with value and status flags.
// Depends on qte_pkg for the default data width.
interface qte_rsp_if #(
    parameter int DATA_WIDTH = qte_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] value;
    logic                         overflow;
    logic                         length_error;

    modport source (output valid, value, overflow, length_error, input ready);
    modport sink   (input valid, value, overflow, length_error, output ready);
endinterface

// ===== rtl/core/quartic_trajectory_evaluator.sv =====
// Quartic trajectory evaluator: APB register file, coefficient builder, Horner pipeline.
// One query per cycle sustained while the output is not stalled and the coefficients are ready.
// After reset or any register write the coefficients rebuild (bit-serial multiplier for four
// products, then bit-serial divider for two quotients, then a scaling step);
// i_req.ready stays low meanwhile. Reset is synchronous, active low, and restores defaults.
// Depends on qte_pkg, qte_req_if, qte_rsp_if and qte_coef.
module quartic_trajectory_evaluator #(
    parameter int  DATA_WIDTH = qte_pkg::DATA_WIDTH_DEF,
    parameter int  FRAC_BITS  = qte_pkg::FRAC_BITS_DEF,
    localparam int PDW        = (DATA_WIDTH > 32) ? 64 : 32,
    localparam int ASH        = (DATA_WIDTH > 32) ? 3 : 2,
    localparam int AW         = $clog2(qte_pkg::NUM_REGS * (1 << ASH))
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    qte_req_if.sink          i_req,
    qte_rsp_if.source        o_rsp,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AW-1:0]    paddr,
    input  logic [PDW-1:0]   pwdata,
    output logic [PDW-1:0]   prdata,
    output logic             pready
);

    localparam int W     = qte_pkg::WIDE_W;
    localparam int STEPS = 4;            // Horner multiply-add steps
    localparam int NST   = 2 * STEPS + 2; // entry, two per step, output
    localparam int PHW   = 31 + DATA_WIDTH;
    localparam int PRW   = 63 + DATA_WIDTH;
    localparam logic signed [W-1:0] DMAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
    localparam logic signed [W-1:0] DMIN = -DMAX - 64'sd1;

    // ------------------------------------------------------------------
    // Register file. Writes land in the access phase; reads are decoded
    // straight from the address.
    // ------------------------------------------------------------------
    logic signed [DATA_WIDTH-1:0]     r_cfg [qte_pkg::NUM_REGS];
    logic [qte_pkg::REG_IDX_W-1:0]    reg_idx;
    logic                             reg_hit;
    logic                             cfg_wr;

    assign reg_idx = paddr[AW-1:ASH];
    assign reg_hit = (reg_idx <= qte_pkg::REG_SEG_LENGTH);
    assign cfg_wr  = psel && penable && pwrite && reg_hit;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < qte_pkg::NUM_REGS; i++) begin
                r_cfg[i] <= '0;
            end
            r_cfg[qte_pkg::REG_SEG_LENGTH] <= DATA_WIDTH'(1) << FRAC_BITS;
        end else if (cfg_wr) begin
            r_cfg[reg_idx] <= pwdata[DATA_WIDTH-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_hit) begin
            prdata = PDW'(unsigned'(r_cfg[reg_idx]));
        end
    end

    // ------------------------------------------------------------------
    // Coefficient builder: holds c3, c4 and the derivative-scaled copies.
    // ------------------------------------------------------------------
    qte_pkg::t_coef coef;
    logic           coef_ready;

    qte_coef #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cfg_wr),
        .i_cfg   (r_cfg),
        .o_coef  (coef),
        .o_ready (coef_ready)
    );

    // Horner coefficient j for a derivative order. Higher orders pad with
    // leading zeros so every item runs the same four multiply-add steps;
    // a zero accumulator passes the next coefficient through untouched.
    function automatic logic signed [W-1:0] coef_sel(input qte_pkg::t_coef c,
                                                     input logic [2:0]     op,
                                                     input int             j);
        logic signed [W-1:0] lst [STEPS+1];
        for (int i = 0; i <= STEPS; i++) begin
            lst[i] = '0;
        end
        unique case (op)
            qte_pkg::ORD_POS: begin
                lst[0] = c.k4;
                lst[1] = c.k3;
                lst[2] = c.k2;
                lst[3] = c.sv;
                lst[4] = c.sp;
            end
            qte_pkg::ORD_VEL: begin
                lst[1] = c.k4x4;
                lst[2] = c.k3x3;
                lst[3] = c.k2x2;
                lst[4] = c.sv;
            end
            qte_pkg::ORD_ACC: begin
                lst[2] = c.k4x12;
                lst[3] = c.k3x6;
                lst[4] = c.k2x2;
            end
            qte_pkg::ORD_JERK: begin
                lst[3] = c.k4x24;
                lst[4] = c.k3x6;
            end
            qte_pkg::ORD_SNAP: begin
                lst[4] = c.k4x24;
            end
            default: begin
                lst[0] = '0;
            end
        endcase
        return lst[j];
    endfunction

    // Saturation of the scaled coefficients that an order uses
    function automatic logic scale_flag(input qte_pkg::t_coef c, input logic [2:0] op);
        logic f;
        unique case (op)
            qte_pkg::ORD_VEL:  f = c.f4x4 | c.f3x3 | c.f2x2;
            qte_pkg::ORD_ACC:  f = c.f4x12 | c.f3x6 | c.f2x2;
            qte_pkg::ORD_JERK: f = c.f4x24 | c.f3x6;
            qte_pkg::ORD_SNAP: f = c.f4x24;
            default:           f = 1'b0;
        endcase
        return f;
    endfunction

    // ------------------------------------------------------------------
    // Evaluation pipeline.
    // Stage 0      : capture query, load leading coefficient.
    // Stage 2s+1   : partial products of |acc| * |t| (two 31-bit halves).
    // Stage 2s+2   : combine, round, saturate, add next coefficient.
    // Stage 9      : saturate to the output width; output register.
    // Each stage advances when it is empty or its successor advances, so
    // bubbles collapse and a stalled output holds everything behind it.
    // ------------------------------------------------------------------
    logic [NST-1:0]                r_v;
    logic [NST-1:0]                stage_en;
    logic [2:0]                    r_op  [NST-1];
    logic                          r_e   [NST-1];
    logic                          r_f   [NST-1];
    logic signed [DATA_WIDTH-1:0]  r_t   [2*STEPS-1];
    logic signed [W-1:0]           r_acc [STEPS+1];
    logic [PHW-1:0]                r_pph [STEPS];
    logic [PHW-1:0]                r_ppl [STEPS];
    logic                          r_neg [STEPS];
    logic signed [DATA_WIDTH-1:0]  r_val;
    logic                          r_ovf;
    logic                          r_err;
    logic                          in_take;

    always_comb begin
        stage_en[NST-1] = !r_v[NST-1] || o_rsp.ready;
        for (int k = NST - 2; k >= 0; k--) begin
            stage_en[k] = !r_v[k] || stage_en[k+1];
        end
    end

    assign i_req.ready = stage_en[0] && coef_ready;
    assign in_take     = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (stage_en[0]) begin
                r_v[0] <= in_take;
            end
            for (int k = 1; k < NST; k++) begin
                if (stage_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Entry stage
    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_op[0]  <= i_req.op;
            r_t[0]   <= i_req.param_value;
            r_e[0]   <= coef.len_err;
            r_f[0]   <= coef.cf | scale_flag(coef, i_req.op);
            r_acc[0] <= coef_sel(coef, i_req.op, 0);
        end
    end

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        localparam int KM = 2 * s + 1;
        localparam int KA = 2 * s + 2;

        logic signed [W-1:0]          acc_in;
        logic signed [DATA_WIDTH-1:0] t_in;
        logic [W-1:0]                 amag;
        logic [DATA_WIDTH-1:0]        tmag;
        logic [PRW-1:0]               prod;
        logic [PRW-1:0]               q;
        logic                         sat;
        logic signed [W-1:0]          mval;
        qte_pkg::t_wres               sum;

        always_comb begin
            acc_in = r_acc[s];
            t_in   = r_t[KM-1];
            amag   = acc_in[W-1] ? W'(-acc_in) : W'(acc_in);
            tmag   = t_in[DATA_WIDTH-1] ? DATA_WIDTH'(-t_in) : DATA_WIDTH'(t_in);

            prod = (PRW'(r_pph[s]) << 31) + PRW'(r_ppl[s])
                   + (PRW'(1) << (FRAC_BITS - 1));
            q    = prod >> FRAC_BITS;
            sat  = (q > PRW'(qte_pkg::WIDE_MAX_U));
            mval = sat ? qte_pkg::WIDE_MAX : $signed(q[W-1:0]);
            if (r_neg[s]) begin
                mval = -mval;
            end
            sum = qte_pkg::addw(mval, coef_sel(coef, r_op[KM], s + 1));
        end

        always_ff @(posedge i_clk) begin
            if (stage_en[KM]) begin
                r_pph[s] <= PHW'(amag[61:31]) * PHW'(tmag);
                r_ppl[s] <= PHW'(amag[30:0]) * PHW'(tmag);
                r_neg[s] <= acc_in[W-1] ^ t_in[DATA_WIDTH-1];
                r_op[KM] <= r_op[KM-1];
                r_e[KM]  <= r_e[KM-1];
                r_f[KM]  <= r_f[KM-1];
            end
            if (stage_en[KA]) begin
                r_acc[s+1] <= sum.v;
                r_op[KA]   <= r_op[KM];
                r_e[KA]    <= r_e[KM];
                r_f[KA]    <= r_f[KM] | sat | sum.f;
            end
        end

        // Carry t along only as far as the last multiply needs it
        if (s < STEPS - 1) begin : g_tpass
            always_ff @(posedge i_clk) begin
                if (stage_en[KM]) begin
                    r_t[KM] <= r_t[KM-1];
                end
                if (stage_en[KA]) begin
                    r_t[KA] <= r_t[KM];
                end
            end
        end
    end

    // Output stage: bad length wins, then unknown order, then saturation
    always_ff @(posedge i_clk) begin
        if (stage_en[NST-1]) begin
            if (r_e[NST-2]) begin
                r_val <= '0;
                r_ovf <= 1'b0;
                r_err <= 1'b1;
            end else if (r_op[NST-2] > qte_pkg::ORD_SNAP) begin
                r_val <= '0;
                r_ovf <= 1'b0;
                r_err <= 1'b0;
            end else if (r_acc[STEPS] > DMAX) begin
                r_val <= DMAX[DATA_WIDTH-1:0];
                r_ovf <= 1'b1;
                r_err <= 1'b0;
            end else if (r_acc[STEPS] < DMIN) begin
                r_val <= DMIN[DATA_WIDTH-1:0];
                r_ovf <= 1'b1;
                r_err <= 1'b0;
            end else begin
                r_val <= r_acc[STEPS][DATA_WIDTH-1:0];
                r_ovf <= r_f[NST-2];
                r_err <= 1'b0;
            end
        end
    end

    assign o_rsp.valid        = r_v[NST-1];
    assign o_rsp.value        = r_val;
    assign o_rsp.overflow     = r_ovf;
    assign o_rsp.length_error = r_err;

endmodule

// ===== rtl/core/qte_coef.sv =====
// Coefficient builder: bit-serial multiplier and restoring divider under a small sequencer.
// Depends on qte_pkg (types, saturating helpers, register indexes).
module qte_coef #(
    parameter int DATA_WIDTH = qte_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = qte_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [DATA_WIDTH-1:0] i_cfg [qte_pkg::NUM_REGS],
    output qte_pkg::t_coef               o_coef,
    output logic                         o_ready
);

    localparam int W = qte_pkg::WIDE_W;

    qte_pkg::t_cseq r_st, n_st;
    logic [6:0]     r_cnt, n_cnt;
    logic [2*W-1:0] r_prod, n_prod;
    logic [W-1:0]   r_rem, n_rem;
    logic [2*W-1:0] r_quo, n_quo;
    logic           r_cf, n_cf;

    logic signed [W-1:0] r_g, n_g, r_hl, n_hl, r_l2, n_l2, r_l3, n_l3;
    logic signed [W-1:0] r_k3, n_k3, r_k4, n_k4;
    logic signed [W-1:0] r_k4x4, n_k4x4, r_k4x12, n_k4x12, r_k4x24, n_k4x24;
    logic signed [W-1:0] r_k3x3, n_k3x3, r_k3x6, n_k3x6, r_k2x2, n_k2x2;
    logic                r_f4x4, n_f4x4, r_f4x12, n_f4x12, r_f4x24, n_f4x24;
    logic                r_f3x3, n_f3x3, r_f3x6, n_f3x6, r_f2x2, n_f2x2;

    logic signed [W-1:0] sp, sv, sa, ev, ea, len, k2;
    qte_pkg::t_wres      h, g1, g2, qm, dq, num3, den3, num4, den4, m3, m2;
    qte_pkg::t_wres      s4, s12, s24, s3, s6, s2;
    logic signed [W-1:0] ma, nu, de;
    logic [W-1:0]        amag, bmag, nmag, dmag, rem2;
    logic                mneg, dneg, qb, dbit;
    logic [2*W-1:0]      mul_sum, pr, q, dnum;

    assign sp  = W'(i_cfg[qte_pkg::REG_START_POS]);
    assign sv  = W'(i_cfg[qte_pkg::REG_START_VEL]);
    assign sa  = W'(i_cfg[qte_pkg::REG_START_ACC]);
    assign ev  = W'(i_cfg[qte_pkg::REG_END_VEL]);
    assign ea  = W'(i_cfg[qte_pkg::REG_END_ACC]);
    assign len = W'(i_cfg[qte_pkg::REG_SEG_LENGTH]);

    // Halve with rounding away from zero
    assign k2 = (sa >= 0) ? ((sa + 64'sd1) >>> 1) : -((-sa + 64'sd1) >>> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= qte_pkg::CS_GP;
            r_cnt  <= '0;
            r_prod <= '0;
            r_rem  <= '0;
            r_quo  <= '0;
            r_cf   <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_cnt  <= n_cnt;
            r_prod <= n_prod;
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_cf   <= n_cf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g     <= n_g;
        r_hl    <= n_hl;
        r_l2    <= n_l2;
        r_l3    <= n_l3;
        r_k3    <= n_k3;
        r_k4    <= n_k4;
        r_k4x4  <= n_k4x4;
        r_k4x12 <= n_k4x12;
        r_k4x24 <= n_k4x24;
        r_k3x3  <= n_k3x3;
        r_k3x6  <= n_k3x6;
        r_k2x2  <= n_k2x2;
        r_f4x4  <= n_f4x4;
        r_f4x12 <= n_f4x12;
        r_f4x24 <= n_f4x24;
        r_f3x3  <= n_f3x3;
        r_f3x6  <= n_f3x6;
        r_f2x2  <= n_f2x2;
    end

    always_comb begin
        n_st    = r_st;
        n_cnt   = r_cnt;
        n_prod  = r_prod;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cf    = r_cf;
        n_g     = r_g;
        n_hl    = r_hl;
        n_l2    = r_l2;
        n_l3    = r_l3;
        n_k3    = r_k3;
        n_k4    = r_k4;
        n_k4x4  = r_k4x4;
        n_k4x12 = r_k4x12;
        n_k4x24 = r_k4x24;
        n_k3x3  = r_k3x3;
        n_k3x6  = r_k3x6;
        n_k2x2  = r_k2x2;
        n_f4x4  = r_f4x4;
        n_f4x12 = r_f4x12;
        n_f4x24 = r_f4x24;
        n_f3x3  = r_f3x3;
        n_f3x6  = r_f3x6;
        n_f2x2  = r_f2x2;

        h = qte_pkg::addw(ea, -sa);

        // Multiplier: one bit of the length per cycle, most significant first
        unique case (r_st)
            qte_pkg::CS_GP: ma = sa;
            qte_pkg::CS_HL: ma = h.v;
            qte_pkg::CS_L3: ma = r_l2;
            default:        ma = len;
        endcase
        amag    = ma[W-1] ? W'(-ma) : W'(ma);
        bmag    = len[W-1] ? W'(-len) : W'(len);
        mneg    = ma[W-1] ^ len[W-1];
        mul_sum = (r_prod << 1) + (bmag[~r_cnt[5:0]] ? {{W{1'b0}}, amag} : '0);
        pr      = mul_sum + ((2*W)'(1) << (FRAC_BITS - 1));
        q       = pr >> FRAC_BITS;
        qm.f    = (q > {{W{1'b0}}, qte_pkg::WIDE_MAX_U});
        qm.v    = qm.f ? qte_pkg::WIDE_MAX : $signed(q[W-1:0]);
        if (mneg) begin
            qm.v = -qm.v;
        end

        // Divider operands
        m3   = qte_pkg::mulk(r_g, 5'd3);
        m2   = qte_pkg::mulk(r_g, 5'd2);
        num3 = qte_pkg::addw(m3.v, -r_hl);
        den3 = qte_pkg::mulk(r_l2, 5'd3);
        num4 = qte_pkg::addw(r_hl, -m2.v);
        den4 = qte_pkg::mulk(r_l3, 5'd4);
        if (r_st == qte_pkg::CS_K4) begin
            nu = num4.v;
            de = den4.v;
        end else begin
            nu = num3.v;
            de = den3.v;
        end
        nmag = nu[W-1] ? W'(-nu) : W'(nu);
        dmag = de[W-1] ? W'(-de) : W'(de);
        dneg = nu[W-1] ^ de[W-1];
        dnum = ({{W{1'b0}}, nmag} << FRAC_BITS) + {{W{1'b0}}, dmag >> 1};
        dbit = dnum[~r_cnt];
        rem2 = {r_rem[W-2:0], dbit};
        qb   = (rem2 >= dmag);
        dq.f = 1'b0;
        if (dmag == '0) begin
            dq.f = (nmag != '0);
            dq.v = (nmag == '0) ? '0 : qte_pkg::WIDE_MAX;
        end else begin
            dq.f = ({r_quo[2*W-2:0], qb} > {{W{1'b0}}, qte_pkg::WIDE_MAX_U});
            dq.v = dq.f ? qte_pkg::WIDE_MAX : $signed(r_quo[W-2:0] << 1 | W'(qb));
        end
        if (dneg) begin
            dq.v = -dq.v;
        end

        g1  = qte_pkg::addw(ev, -qm.v);
        g2  = qte_pkg::addw(g1.v, -sv);
        s4  = qte_pkg::mulk(r_k4, 5'd4);
        s12 = qte_pkg::mulk(r_k4, 5'd12);
        s24 = qte_pkg::mulk(r_k4, 5'd24);
        s3  = qte_pkg::mulk(r_k3, 5'd3);
        s6  = qte_pkg::mulk(r_k3, 5'd6);
        s2  = qte_pkg::mulk(k2, 5'd2);

        unique case (r_st)
            qte_pkg::CS_GP, qte_pkg::CS_HL, qte_pkg::CS_L2, qte_pkg::CS_L3: begin
                n_prod = mul_sum;
                n_cnt  = r_cnt + 7'd1;
                if (r_cnt[5:0] == 6'h3F) begin
                    n_prod = '0;
                    n_cnt  = '0;
                    unique case (r_st)
                        qte_pkg::CS_GP: begin
                            n_g  = g2.v;
                            n_cf = r_cf | qm.f | g1.f | g2.f;
                            n_st = qte_pkg::CS_HL;
                        end
                        qte_pkg::CS_HL: begin
                            n_hl = qm.v;
                            n_cf = r_cf | qm.f | h.f;
                            n_st = qte_pkg::CS_L2;
                        end
                        qte_pkg::CS_L2: begin
                            n_l2 = qm.v;
                            n_cf = r_cf | qm.f;
                            n_st = qte_pkg::CS_L3;
                        end
                        default: begin
                            n_l3 = qm.v;
                            n_cf = r_cf | qm.f;
                            n_st = qte_pkg::CS_K3;
                        end
                    endcase
                end
            end
            qte_pkg::CS_K3, qte_pkg::CS_K4: begin
                n_rem = qb ? rem2 - dmag : rem2;
                n_quo = {r_quo[2*W-2:0], qb};
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'h7F) begin
                    n_rem = '0;
                    n_quo = '0;
                    n_cnt = '0;
                    if (r_st == qte_pkg::CS_K3) begin
                        n_k3 = dq.v;
                        n_cf = r_cf | dq.f | m3.f | num3.f | den3.f;
                        n_st = qte_pkg::CS_K4;
                    end else begin
                        n_k4 = dq.v;
                        n_cf = r_cf | dq.f | m2.f | num4.f | den4.f;
                        n_st = qte_pkg::CS_SCALE;
                    end
                end
            end
            qte_pkg::CS_SCALE: begin
                n_k4x4  = s4.v;
                n_k4x12 = s12.v;
                n_k4x24 = s24.v;
                n_k3x3  = s3.v;
                n_k3x6  = s6.v;
                n_k2x2  = s2.v;
                n_f4x4  = s4.f;
                n_f4x12 = s12.f;
                n_f4x24 = s24.f;
                n_f3x3  = s3.f;
                n_f3x6  = s6.f;
                n_f2x2  = s2.f;
                n_st    = qte_pkg::CS_READY;
            end
            default: begin
                n_st = qte_pkg::CS_READY;
            end
        endcase

        // A register write restarts the whole build
        if (i_start) begin
            n_st   = qte_pkg::CS_GP;
            n_cnt  = '0;
            n_prod = '0;
            n_rem  = '0;
            n_quo  = '0;
            n_cf   = 1'b0;
        end
    end

    assign o_ready = (r_st == qte_pkg::CS_READY);

    always_comb begin
        o_coef.sp      = sp;
        o_coef.sv      = sv;
        o_coef.k2      = k2;
        o_coef.k3      = r_k3;
        o_coef.k4      = r_k4;
        o_coef.k4x4    = r_k4x4;
        o_coef.k4x12   = r_k4x12;
        o_coef.k4x24   = r_k4x24;
        o_coef.k3x3    = r_k3x3;
        o_coef.k3x6    = r_k3x6;
        o_coef.k2x2    = r_k2x2;
        o_coef.cf      = r_cf;
        o_coef.f4x4    = r_f4x4;
        o_coef.f4x12   = r_f4x12;
        o_coef.f4x24   = r_f4x24;
        o_coef.f3x3    = r_f3x3;
        o_coef.f3x6    = r_f3x6;
        o_coef.f2x2    = r_f2x2;
        o_coef.len_err = i_cfg[qte_pkg::REG_SEG_LENGTH][DATA_WIDTH-1]
                         || (i_cfg[qte_pkg::REG_SEG_LENGTH] == '0);
    end

endmodule

// ===== test/quartic_trajectory_evaluator_test.sv =====
// Self-checking bench for quartic_trajectory_evaluator: APB setup of the boundary registers,
// directed and random queries on the request channel, results checked against a bit-exact predictor.
// Depends on qte_pkg, qte_req_if, qte_rsp_if and the block itself.
module quartic_trajectory_evaluator_test;

    typedef logic signed [63:0] t_wide;

    typedef struct {
        logic signed [31:0] value;
        logic               overflow;
        logic               length_error;
    } t_traj_result;

    // Holds a copy of the registers, predicts each query and keeps the
    // results still owed by the block in order.
    class trajectory_scoreboard;
        logic signed [31:0] regs [qte_pkg::NUM_REGS];
        t_traj_result       owed [$];
        int                 errors;
        int                 checked;

        function new();
            for (int i = 0; i < qte_pkg::NUM_REGS; i++) regs[i] = '0;
            regs[qte_pkg::REG_SEG_LENGTH] = 32'sh0001_0000;
            errors  = 0;
            checked = 0;
        endfunction

        function automatic t_wide clamp(logic signed [65:0] v, inout bit f);
            if (v > qte_pkg::WIDE_MAX) begin
                f = 1;
                return qte_pkg::WIDE_MAX;
            end
            if (v < -qte_pkg::WIDE_MAX) begin
                f = 1;
                return -qte_pkg::WIDE_MAX;
            end
            return v[63:0];
        endfunction

        function automatic t_wide add_sat(t_wide a, t_wide b, inout bit f);
            logic signed [65:0] s;
            s = a;
            s = s + b;
            return clamp(s, f);
        endfunction

        function automatic t_wide scale_sat(t_wide a, int k, inout bit f);
            t_wide lim;
            lim = qte_pkg::WIDE_MAX / k;
            if (a > lim) begin
                f = 1;
                return qte_pkg::WIDE_MAX;
            end
            if (a < -lim) begin
                f = 1;
                return -qte_pkg::WIDE_MAX;
            end
            return a * k;
        endfunction

        function automatic logic [127:0] mag(t_wide a);
            logic [127:0] m;
            m = (a < 0) ? -a : a;
            return {64'd0, m[63:0]};
        endfunction

        function automatic t_wide from_mag(logic [127:0] m, bit neg, inout bit f);
            t_wide r;
            if (m > {64'd0, qte_pkg::WIDE_MAX_U}) begin
                f = 1;
                r = qte_pkg::WIDE_MAX;
            end else begin
                r = m[63:0];
            end
            return neg ? -r : r;
        endfunction

        // Fixed-point product, rounded half away from zero
        function automatic t_wide fx_mul(t_wide a, t_wide b, inout bit f);
            logic [127:0] p;
            p = mag(a) * mag(b);
            p = (p + (128'd1 << (qte_pkg::FRAC_BITS_DEF - 1))) >> qte_pkg::FRAC_BITS_DEF;
            return from_mag(p, (a < 0) != (b < 0), f);
        endfunction

        // Fixed-point quotient, rounded; a zero divisor saturates unless the dividend is zero too
        function automatic t_wide fx_div(t_wide a, t_wide b, inout bit f);
            logic [127:0] n;
            logic [127:0] d;
            if (b == 0) begin
                if (a == 0) return 0;
                f = 1;
                return (a > 0) ? qte_pkg::WIDE_MAX : -qte_pkg::WIDE_MAX;
            end
            d = mag(b);
            n = (mag(a) << qte_pkg::FRAC_BITS_DEF) + (d >> 1);
            return from_mag(n / d, (a < 0) != (b < 0), f);
        endfunction

        function automatic t_traj_result evaluate(logic [2:0] op, logic signed [31:0] t_in);
            t_traj_result r;
            bit    cf, ef;
            t_wide sp, sv, sa, ev, ea, len, t, k2, k3, k4, g, h, hl, l2, l3, acc;
            cf = 0;
            ef = 0;
            sp = regs[qte_pkg::REG_START_POS];
            sv = regs[qte_pkg::REG_START_VEL];
            sa = regs[qte_pkg::REG_START_ACC];
            ev = regs[qte_pkg::REG_END_VEL];
            ea = regs[qte_pkg::REG_END_ACC];
            len = regs[qte_pkg::REG_SEG_LENGTH];
            t = t_in;
            r.value = 0;
            r.overflow = 0;
            r.length_error = 0;
            if (len <= 0) begin
                r.length_error = 1;
                return r;
            end
            if (op > qte_pkg::ORD_SNAP) return r;

            k2 = (sa >= 0) ? ((sa + 1) >>> 1) : -((-sa + 1) >>> 1);
            g  = add_sat(add_sat(ev, -fx_mul(sa, len, cf), cf), -sv, cf);
            h  = add_sat(ea, -sa, cf);
            hl = fx_mul(h, len, cf);
            l2 = fx_mul(len, len, cf);
            l3 = fx_mul(l2, len, cf);
            k3 = fx_div(add_sat(scale_sat(g, 3, cf), -hl, cf), scale_sat(l2, 3, cf), cf);
            k4 = fx_div(add_sat(hl, -scale_sat(g, 2, cf), cf), scale_sat(l3, 4, cf), cf);

            // Horner over the scaled coefficients of the chosen derivative
            case (op)
                qte_pkg::ORD_POS: begin
                    acc = add_sat(fx_mul(k4, t, ef), k3, ef);
                    acc = add_sat(fx_mul(acc, t, ef), k2, ef);
                    acc = add_sat(fx_mul(acc, t, ef), sv, ef);
                    acc = add_sat(fx_mul(acc, t, ef), sp, ef);
                end
                qte_pkg::ORD_VEL: begin
                    acc = add_sat(fx_mul(scale_sat(k4, 4, ef), t, ef),
                                  scale_sat(k3, 3, ef), ef);
                    acc = add_sat(fx_mul(acc, t, ef), scale_sat(k2, 2, ef), ef);
                    acc = add_sat(fx_mul(acc, t, ef), sv, ef);
                end
                qte_pkg::ORD_ACC: begin
                    acc = add_sat(fx_mul(scale_sat(k4, 12, ef), t, ef),
                                  scale_sat(k3, 6, ef), ef);
                    acc = add_sat(fx_mul(acc, t, ef), scale_sat(k2, 2, ef), ef);
                end
                qte_pkg::ORD_JERK: begin
                    acc = add_sat(fx_mul(scale_sat(k4, 24, ef), t, ef),
                                  scale_sat(k3, 6, ef), ef);
                end
                default: begin
                    acc = scale_sat(k4, 24, ef);
                end
            endcase
            if (acc > 64'sh7FFF_FFFF) begin
                acc = 64'sh7FFF_FFFF;
                ef = 1;
            end
            if (acc < -64'sh8000_0000) begin
                acc = -64'sh8000_0000;
                ef = 1;
            end
            r.value = acc[31:0];
            r.overflow = cf | ef;
            return r;
        endfunction

        function void note_query(logic [2:0] op, logic signed [31:0] t_in);
            owed.push_back(evaluate(op, t_in));
        endfunction

        function void check_result(t_traj_result got);
            t_traj_result want;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result value=%h ovf=%b lerr=%b", $time,
                         got.value, got.overflow, got.length_error);
                errors++;
                return;
            end
            want = owed.pop_front();
            checked++;
            if (got.value !== want.value) begin
                $display("%0t: value expected %h actual %h", $time, want.value, got.value);
                errors++;
            end
            if (got.overflow !== want.overflow) begin
                $display("%0t: overflow expected %b actual %b", $time,
                         want.overflow, got.overflow);
                errors++;
            end
            if (got.length_error !== want.length_error) begin
                $display("%0t: length_error expected %b actual %b", $time,
                         want.length_error, got.length_error);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    qte_req_if query_ch ();
    qte_rsp_if answer_ch ();

    quartic_trajectory_evaluator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (query_ch),
        .o_rsp   (answer_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    trajectory_scoreboard board = new();
    bit hold_answers;   // ask the receiver for one long hold-off
    bit no_gaps;        // run the sender flat out
    int sent;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Both sides are sampled before the edge's own updates land, so the
    // handshake seen here is the one the block sees.
    always @(posedge i_clk) begin
        t_traj_result got;
        if (i_rst_n) begin
            if (query_ch.valid && query_ch.ready)
                board.note_query(query_ch.op, query_ch.param_value);
            if (answer_ch.valid && answer_ch.ready) begin
                got.value = answer_ch.value;
                got.overflow = answer_ch.overflow;
                got.length_error = answer_ch.length_error;
                board.check_result(got);
            end
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request; the hold
    // outlasts a coefficient rebuild so the pipeline fills behind it
    initial begin
        bit held;
        held = 0;
        answer_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_answers && !held) begin
                answer_ch.ready <= 1'b0;
                repeat (1000) @(posedge i_clk);
                held = 1;
            end else if ($urandom_range(0, 3) == 0) begin
                answer_ch.ready <= 1'b0;
                repeat (gap_len() + 1) @(posedge i_clk);
            end else begin
                answer_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Offer one query and hold it until accepted; valid stays up across
    // back-to-back items
    task automatic send_query(logic [2:0] op, logic signed [31:0] t);
        int gap;
        gap = no_gaps ? 0 : gap_len();
        if (gap > 0) begin
            query_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        query_ch.valid <= 1'b1;
        query_ch.op <= op;
        query_ch.param_value <= t;
        do @(posedge i_clk); while (!(query_ch.valid && query_ch.ready));
        sent++;
    endtask

    task automatic drain();
        query_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.owed.size() != 0) @(posedge i_clk);
        repeat (15) @(posedge i_clk);
    endtask

    // APB write: setup then access; the block rebuilds its coefficients after
    task automatic write_reg(logic [qte_pkg::REG_IDX_W-1:0] idx, logic signed [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.regs[idx] = val;
    endtask

    task automatic write_all(logic signed [31:0] sp, logic signed [31:0] sv,
                             logic signed [31:0] sa, logic signed [31:0] ev,
                             logic signed [31:0] ea, logic signed [31:0] len);
        write_reg(qte_pkg::REG_START_POS, sp);
        write_reg(qte_pkg::REG_START_VEL, sv);
        write_reg(qte_pkg::REG_START_ACC, sa);
        write_reg(qte_pkg::REG_END_VEL, ev);
        write_reg(qte_pkg::REG_END_ACC, ea);
        write_reg(qte_pkg::REG_SEG_LENGTH, len);
    endtask

    // Signed value of random magnitude, raw up to about 2^24, so about 256.0 in Q16.16
    function automatic logic signed [31:0] modest();
        logic signed [31:0] m;
        m = $urandom_range(0, (1 << $urandom_range(4, 24)) - 1);
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    function automatic logic signed [31:0] pick_length();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return $urandom_range(1, 255);          // squares round to zero for 181 and below
        if (r == 1) return -$signed({1'b0, $urandom_range(0, 32'h7FFF)});
        if (r == 2) return $urandom;                        // any value at all
        return $urandom_range(32'h0000_4000, 32'h0008_0000);
    endfunction

    function automatic logic signed [31:0] pick_param(logic signed [31:0] len);
        logic signed [31:0] m;
        if ($urandom_range(0, 3) == 0) return $urandom;
        m = $urandom_range(0, (len > 0 && len < 32'sh0010_0000) ? len + 32'sh2000 : 32'h0004_0000);
        return ($urandom_range(0, 7) == 0) ? -m : m;
    endfunction

    task automatic random_phase(int count, bit full_range, bit pause_midway);
        if (full_range)
            write_all($urandom, $urandom, $urandom, $urandom, $urandom, pick_length());
        else
            write_all(modest(), modest(), modest(), modest(), modest(), pick_length());
        no_gaps = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < count; i++) begin
            if (pause_midway && i == count / 2) drain();
            send_query(3'($urandom_range(0, 7)),
                       pick_param(board.regs[qte_pkg::REG_SEG_LENGTH]));
        end
        no_gaps = 0;
        drain();
    endtask

    initial begin
        logic signed [31:0] corner_t [5];
        corner_t = '{32'sh0, 32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh0001_0000, -32'sh0001_0000};
        sent = 0;
        hold_answers = 0;
        no_gaps = 0;
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        query_ch.valid <= 1'b0;
        query_ch.op <= qte_pkg::ORD_POS;
        query_ch.param_value <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Defaults after reset: every order including the ones above four
        for (int o = 0; o < 8; o++) send_query(3'(o), corner_t[o % 5]);
        drain();

        // Ordinary segment at the corners of the parameter range
        write_all(32'sh0002_0000, 32'sh0001_8000, -32'sh0000_8000,
                  32'sh0000_4000, 32'sh0000_C000, 32'sh0002_0000);
        for (int i = 0; i < 5; i++) send_query(3'(i), corner_t[i]);
        drain();

        // Register extremes with a tiny length: coefficients saturate
        write_all(32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh7FFF_FFFF,
                  -32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0001);
        for (int i = 0; i < 5; i++) send_query(3'(i), corner_t[4 - i]);
        drain();

        // Zero and most negative length: error for any order
        write_reg(qte_pkg::REG_SEG_LENGTH, 32'sh0);
        send_query(qte_pkg::ORD_POS, 32'sh0001_0000);
        send_query(3'd7, 32'sh0);
        drain();
        write_reg(qte_pkg::REG_SEG_LENGTH, -32'sh8000_0000);
        send_query(qte_pkg::ORD_SNAP, -32'sh0001_0000);
        send_query(qte_pkg::ORD_VEL, 32'sh7FFF_FFFF);
        drain();

        // Random segments; one with the receiver held off, one with a sender pause
        for (int p = 0; p < 10; p++) begin
            if (p == 2) hold_answers = 1;
            random_phase(62, (p % 4) == 3, p == 5);
        end

        $display("covered %0d queries over 15 register settings, %0d results checked",
                 sent, board.checked);
        if (board.errors == 0)
            $display("quartic_trajectory_evaluator: match");
        else
            $display("quartic_trajectory_evaluator: mismatch");
        $finish;
    end

    initial begin
        #20000000;
        $display("quartic_trajectory_evaluator: mismatch");
        $finish;
    end
endmodule
